/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the congestion window controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/cwc_pkg.sv */
// Types and constants shared by the congestion window controller modules.
package cwc_pkg;

   // Operation codes of an input item
   localparam logic [1:0] OP_SEND    = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Register map (index taken from byte address bit 2)
   localparam int         CSR_ADDR_W         = 3;
   localparam logic       REG_INIT_THRESHOLD = 1'b0;
   localparam logic [7:0] RESET_THRESHOLD    = 8'd64;

   // Duplicate ACK handling
   localparam logic [7:0] DUP_LIMIT = 8'd3;
   localparam logic [7:0] DUP_MAX   = 8'hFF;
   localparam logic [31:0] PREV_ACK_RESET = 32'hFFFF_FFFF;

   // Q1.16 growth accumulator
   localparam int          ACC_W   = 17;
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   // Serial divider: 65536 / window, four quotient bits a cycle
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = 5;
   localparam int DIV_NUM_W = DIV_BITS * DIV_STEPS;
   localparam int DIV_CNT_W = 3;

   typedef enum logic [1:0] {
      PH_SLOW     = 2'd0,
      PH_AVOID    = 2'd1,
      PH_RECOVERY = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_EVAL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_GROW,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] ack_number;
   } req_item_type;

   typedef struct packed {
      logic        send_granted;
      logic [31:0] send_sequence;
      logic        retransmit_base;
      logic [31:0] window_base;
      logic [7:0]  newly_acked;
      logic [7:0]  window_size;
      logic [7:0]  threshold_now;
      logic [1:0]  phase;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic prep;
      logic eval;
      logic div_start;
      logic grow;
      logic emit;
   } cmd_type;

   // Datapath and divider to controller
   typedef struct packed {
      logic need_grow;
      logic rsp_free;
      logic div_done;
   } status_type;

endpackage

/* src/congestion_window_controller.sv */
// Top level of the congestion window controller: register port, controller and datapath.
//
//   channel   direction  handshake              content
//   req_      in         req_valid / req_stall  op, ack_number
//   rsp_      out        rsp_valid / rsp_stall  one result item per input item
//   csr_      in/out     psel, penable, pready  initial_threshold at byte address 0
//
// A send, timeout or ACK without avoidance growth passes the prep, eval and done
// states from accept to a loaded result register; an in-window ACK in congestion
// avoidance also waits for the serial 65536 / window divider (four quotient bits a cycle).
// Reset is synchronous and clears the window state; no clearing pass is needed.
// A result waiting under rsp_stall does not block the next item from entering,
// but that item holds in its final step until the result register frees.
`include "assert_macros.svh"

module congestion_window_controller #(
   parameter int MAX_WINDOW = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cwc_pkg::req_item_type          req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cwc_pkg::rsp_item_type          rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cwc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int WW = $clog2(MAX_WINDOW + 1);

   logic [7:0]                 init_thr_ff, init_thr_in;
   logic                       thr_wr;
   cwc_pkg::cmd_type           cmd;
   cwc_pkg::status_type        status;
   logic [WW-1:0]              divisor;
   logic [cwc_pkg::ACC_W-1:0]  quotient;
   logic                       need_grow;
   logic                       rsp_free;
   logic                       div_done;

   // Register port
   assign csr_pready = 1'b1;
   assign thr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == cwc_pkg::REG_INIT_THRESHOLD);
   assign init_thr_in = thr_wr ? csr_pwdata[7:0] : init_thr_ff;
   assign csr_prdata  = (csr_paddr[2] == cwc_pkg::REG_INIT_THRESHOLD)
                        ? {24'd0, init_thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_thr_ff <= cwc_pkg::RESET_THRESHOLD;
      end else begin
         init_thr_ff <= init_thr_in;
      end
   end

   assign status.need_grow = need_grow;
   assign status.rsp_free  = rsp_free;
   assign status.div_done  = div_done;

   cwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cwc_divider #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // The written value loads the working threshold in the same edge
   cwc_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .thr_wr      (thr_wr),
      .thr_value   (csr_pwdata[7:0]),
      .quotient    (quotient),
      .divisor     (divisor),
      .need_grow   (need_grow),
      .rsp_free    (rsp_free),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // An accepted item keeps the input side busy on the next cycle
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // The reported window never drops to zero
   `ASSERT_IMPLIES(a_window_nonzero, clock, reset, rsp_valid, rsp_payload.window_size != 8'd0)
   // A grant and a retransmit request never come from the same item
   `ASSERT_IMPLIES(a_grant_excl_retx, clock, reset, rsp_valid,
                   !(rsp_payload.send_granted && rsp_payload.retransmit_base))
   // Acknowledged packets are never reported alongside a grant
   `ASSERT_IMPLIES(a_ack_excl_grant, clock, reset, rsp_valid && rsp_payload.send_granted,
                   rsp_payload.newly_acked == 8'd0)

endmodule

/* src/cwc_divider.sv */
// Serial divider computing 65536 / window, four quotient bits per cycle.
module cwc_divider #(
   parameter int MAX_WINDOW = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]      divisor,
   output logic                                 done,
   output logic [cwc_pkg::ACC_W-1:0]            quotient
);

   localparam int WW = $clog2(MAX_WINDOW + 1);

   logic [cwc_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [WW:0]                   rem_ff, rem_in;
   logic [cwc_pkg::ACC_W-1:0]     quo_ff, quo_in;
   logic [WW-1:0]                 dvs_ff;
   logic [cwc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          last_step;

   assign last_step = busy_ff && (cnt_ff == cwc_pkg::DIV_CNT_W'(cwc_pkg::DIV_STEPS - 1));

   // Restoring division, DIV_BITS steps per cycle
   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = cwc_pkg::DIV_NUM_W'(cwc_pkg::ONE_Q16);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < cwc_pkg::DIV_BITS; i++) begin
            rem_in = {rem_in[WW-1:0], num_in[cwc_pkg::DIV_NUM_W-1]};
            num_in = {num_in[cwc_pkg::DIV_NUM_W-2:0], 1'b0};
            if (rem_in >= {1'b0, dvs_ff}) begin
               rem_in = rem_in - {1'b0, dvs_ff};
               quo_in = {quo_in[cwc_pkg::ACC_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[cwc_pkg::ACC_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + cwc_pkg::DIV_CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/cwc_datapath.sv */
// Window state, per-item evaluation and result register of the controller.
module cwc_datapath #(
   parameter int MAX_WINDOW = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cwc_pkg::cmd_type                  cmd,
   input  cwc_pkg::req_item_type             req_payload,
   input  logic                              thr_wr,
   input  logic [7:0]                        thr_value,
   input  logic [cwc_pkg::ACC_W-1:0]         quotient,
   output logic [$clog2(MAX_WINDOW+1)-1:0]   divisor,
   output logic                              need_grow,
   output logic                              rsp_free,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output cwc_pkg::rsp_item_type             rsp_payload
);

   localparam int WW = $clog2(MAX_WINDOW + 1);
   localparam int TW = (WW > 8) ? WW : 8;
   localparam int CW = TW + 1;

   // Clamp a candidate window to 1..MAX_WINDOW
   function automatic logic [WW-1:0] clamp_win(input logic [CW-1:0] x);
      logic [WW-1:0] r;
      if (x == '0) begin
         r = WW'(1);
      end else if (x > CW'(MAX_WINDOW)) begin
         r = WW'(MAX_WINDOW);
      end else begin
         r = x[WW-1:0];
      end
      return r;
   endfunction

   // Latched item and precomputed distances
   logic [1:0]  op_ff, op_in;
   logic [31:0] ack_ff, ack_in;
   logic [31:0] dist_ff, dist_in;
   logic [31:0] span_ff, span_in;
   logic        is_new_ff, is_new_in;

   // Protocol state
   cwc_pkg::phase_type       phase_ff, phase_in;
   logic [WW-1:0]            window_ff, window_in;
   logic [TW-1:0]            thresh_ff, thresh_in;
   logic [31:0]              base_ff, base_in;
   logic [31:0]              next_ff, next_in;
   logic [31:0]              prev_ack_ff, prev_ack_in;
   logic [7:0]               dup_ff, dup_in;
   logic [cwc_pkg::ACC_W-1:0] acc_ff, acc_in;

   // Per-item result fields
   logic        granted_ff, granted_in;
   logic [31:0] seq_ff, seq_in;
   logic        retx_ff, retx_in;
   logic [7:0]  acked_ff, acked_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   cwc_pkg::rsp_item_type rsp_ff, rsp_next;

   // Evaluation temporaries
   logic [WW+1:0]              w3;
   logic [WW-1:0]              three_q;
   logic                       in_window;
   logic [7:0]                 dup_new;
   logic [WW-1:0]              w1;
   logic [TW-1:0]              t1;
   cwc_pkg::phase_type         p1;
   logic [cwc_pkg::ACC_W:0]    acc_sum;
   logic [WW+7:0]              win_ext;
   logic [TW+7:0]              thr_ext;

   assign w3        = {1'b0, window_ff, 1'b0} + {2'b00, window_ff};
   assign three_q   = w3[WW+1:2];
   assign in_window = (dist_ff != 32'd0) && (dist_ff <= span_ff);
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, quotient};

   // Avoidance growth needs 65536 / window from the divider
   assign need_grow = (op_ff == cwc_pkg::OP_ACK) && (phase_ff == cwc_pkg::PH_AVOID)
                      && in_window;
   assign divisor   = window_ff;

   // Next state of the datapath registers
   always_comb begin
      op_in       = op_ff;
      ack_in      = ack_ff;
      dist_in     = dist_ff;
      span_in     = span_ff;
      is_new_in   = is_new_ff;
      phase_in    = phase_ff;
      window_in   = window_ff;
      thresh_in   = thresh_ff;
      base_in     = base_ff;
      next_in     = next_ff;
      prev_ack_in = prev_ack_ff;
      dup_in      = dup_ff;
      acc_in      = acc_ff;
      granted_in  = granted_ff;
      seq_in      = seq_ff;
      retx_in     = retx_ff;
      acked_in    = acked_ff;
      dup_new     = dup_ff;
      w1          = window_ff;
      t1          = thresh_ff;
      p1          = phase_ff;

      if (cmd.capture) begin
         op_in  = req_payload.op;
         ack_in = req_payload.ack_number;
      end

      if (cmd.prep) begin
         dist_in   = ack_ff - base_ff;
         span_in   = next_ff - base_ff;
         is_new_in = (ack_ff != prev_ack_ff);
      end

      if (cmd.eval) begin
         granted_in = 1'b0;
         seq_in     = 32'd0;
         retx_in    = 1'b0;
         acked_in   = 8'd0;
         case (op_ff)
            cwc_pkg::OP_SEND: begin
               if (span_ff < 32'(window_ff)) begin
                  granted_in = 1'b1;
                  seq_in     = next_ff;
                  next_in    = next_ff + 32'd1;
               end
            end
            cwc_pkg::OP_ACK: begin
               if (is_new_ff) begin
                  dup_new = 8'd0;
               end else if (dup_ff != cwc_pkg::DUP_MAX) begin
                  dup_new = dup_ff + 8'd1;
               end
               dup_in      = dup_new;
               prev_ack_in = ack_ff;
               // Fast recovery entry wins over the slow start exit check
               if (dup_new >= cwc_pkg::DUP_LIMIT) begin
                  t1      = TW'(three_q);
                  w1      = clamp_win(CW'(three_q));
                  p1      = cwc_pkg::PH_RECOVERY;
                  retx_in = 1'b1;
               end else if ((phase_ff == cwc_pkg::PH_SLOW) && (TW'(window_ff) >= thresh_ff)) begin
                  p1 = cwc_pkg::PH_AVOID;
               end
               // Window moves by the phase held at the start of the item
               if (phase_ff == cwc_pkg::PH_RECOVERY) begin
                  if (is_new_ff) begin
                     p1 = cwc_pkg::PH_AVOID;
                     w1 = clamp_win(CW'(thresh_ff));
                  end
               end else if (in_window) begin
                  if (phase_ff == cwc_pkg::PH_SLOW) begin
                     w1 = clamp_win(CW'(w1) + CW'(1));
                  end
                  acked_in = (dist_ff > 32'd255) ? 8'hFF : dist_ff[7:0];
                  base_in  = ack_ff;
               end
               window_in = w1;
               thresh_in = t1;
               phase_in  = p1;
            end
            cwc_pkg::OP_TIMEOUT: begin
               thresh_in = TW'(three_q);
               window_in = WW'(1);
               phase_in  = cwc_pkg::PH_SLOW;
               retx_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Fractional growth in congestion avoidance
      if (cmd.grow) begin
         if (acc_sum > {1'b0, cwc_pkg::ONE_Q16}) begin
            acc_in    = cwc_pkg::ACC_W'(acc_sum - {1'b0, cwc_pkg::ONE_Q16});
            window_in = clamp_win(CW'(window_ff) + CW'(1));
         end else begin
            acc_in = acc_sum[cwc_pkg::ACC_W-1:0];
         end
      end

      if (thr_wr) begin
         thresh_in = TW'(thr_value);
      end
   end

   // Result item assembly, with 8-bit saturation of window and threshold
   always_comb begin
      win_ext = {8'd0, window_ff};
      thr_ext = {8'd0, thresh_ff};
      rsp_next.send_granted    = granted_ff;
      rsp_next.send_sequence   = seq_ff;
      rsp_next.retransmit_base = retx_ff;
      rsp_next.window_base     = base_ff;
      rsp_next.newly_acked     = acked_ff;
      rsp_next.window_size     = (win_ext > (WW+8)'(255)) ? 8'hFF : win_ext[7:0];
      rsp_next.threshold_now   = (thr_ext > (TW+8)'(255)) ? 8'hFF : thr_ext[7:0];
      rsp_next.phase           = phase_ff;
   end

   // Output handshake
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and protocol state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cwc_pkg::PH_SLOW;
         window_ff    <= WW'(1);
         thresh_ff    <= TW'(cwc_pkg::RESET_THRESHOLD);
         base_ff      <= '0;
         next_ff      <= '0;
         prev_ack_ff  <= cwc_pkg::PREV_ACK_RESET;
         dup_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         window_ff    <= window_in;
         thresh_ff    <= thresh_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         prev_ack_ff  <= prev_ack_in;
         dup_ff       <= dup_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ack_ff     <= ack_in;
      dist_ff    <= dist_in;
      span_ff    <= span_in;
      is_new_ff  <= is_new_in;
      granted_ff <= granted_in;
      seq_ff     <= seq_in;
      retx_ff    <= retx_in;
      acked_ff   <= acked_in;
      if (cmd.emit) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* src/cwc_ctrl.sv */
// Sequencing state machine of the congestion window controller.
module cwc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cwc_pkg::status_type status,
   output cwc_pkg::cmd_type    cmd
);

   cwc_pkg::ctrl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cwc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cwc_pkg::ST_PREP;
            end
         end
         cwc_pkg::ST_PREP: begin
            state_in = cwc_pkg::ST_EVAL;
         end
         cwc_pkg::ST_EVAL: begin
            state_in = status.need_grow ? cwc_pkg::ST_DIV_START : cwc_pkg::ST_DONE;
         end
         cwc_pkg::ST_DIV_START: begin
            state_in = cwc_pkg::ST_DIV_WAIT;
         end
         cwc_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = cwc_pkg::ST_GROW;
            end
         end
         cwc_pkg::ST_GROW: begin
            state_in = cwc_pkg::ST_DONE;
         end
         cwc_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               state_in = cwc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cwc_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         cwc_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         cwc_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
         end
         cwc_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         cwc_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
         end
         cwc_pkg::ST_GROW: begin
            cmd.grow = 1'b1;
         end
         cwc_pkg::ST_DONE: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
